/* sv/vbbc_pkg.sv */
`timescale 1ns / 1ps

package vbbc_pkg;

  // Field and register widths.
  localparam int unsigned ID_W      = 30;
  localparam int unsigned EXT_W     = 11;
  localparam int unsigned OUT_W     = 10;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned TOTAL_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 64;
  localparam int unsigned M_TUSER_W = 3;
  localparam int unsigned NUM_AXES  = 3;

  localparam int unsigned MAX_DIM_DEFAULT = 1024;

  localparam logic [EXT_W-1:0] EXTENT_RESET = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;

  // Result kinds and axis codes.
  localparam logic KIND_COORD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // An extent of zero acts as one, and an extent above the volume limit
  // acts as the limit.
  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] value,
                                                  input int unsigned max_dim);
    logic [EXT_W-1:0] result;
    if (value == '0) begin
      result = EXT_W'(1);
    end else if (32'(value) > max_dim) begin
      result = EXT_W'(max_dim);
    end else begin
      result = value;
    end
    return result;
  endfunction

endpackage

/* sv/vbbc_split.sv */
`timescale 1ns / 1ps

module vbbc_split #(
  parameter int unsigned MAX_DIM = vbbc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [vbbc_pkg::ID_W-1:0]               voxel_id,
  input  logic [vbbc_pkg::EXT_W-1:0]              ext_x,
  input  logic [vbbc_pkg::EXT_W-1:0]              ext_y,
  output logic                                    done,
  output logic [vbbc_pkg::EXT_W-1:0]              coord_i,
  output logic [vbbc_pkg::EXT_W-1:0]              coord_j,
  output logic [$clog2(MAX_DIM)-1:0]              coord_k
);
  import vbbc_pkg::*;

  localparam int unsigned KW    = $clog2(MAX_DIM);
  localparam int unsigned CNT_W = $clog2(ID_W);

  // Two restoring dividers run in a chain, one bit per cycle. The first
  // divides the id by the x extent; each quotient bit it produces feeds the
  // second, which divides that quotient by the y extent.
  logic [ID_W-1:0]  id_sr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [EXT_W-1:0] rem_a;
  logic [EXT_W-1:0] rem_b;
  logic [KW-1:0]    quo_k;
  logic             k_ovf;

  logic [EXT_W:0]   trial_a;
  logic [EXT_W:0]   trial_b;
  logic             bit_a;
  logic             bit_b;
  logic [EXT_W-1:0] rem_a_next;
  logic [EXT_W-1:0] rem_b_next;

  always_comb begin
    trial_a    = {rem_a, id_sr[ID_W-1]};
    bit_a      = trial_a >= {1'b0, ext_x};
    rem_a_next = bit_a ? EXT_W'(trial_a - {1'b0, ext_x}) : EXT_W'(trial_a);
    trial_b    = {rem_b, bit_a};
    bit_b      = trial_b >= {1'b0, ext_y};
    rem_b_next = bit_b ? EXT_W'(trial_b - {1'b0, ext_y}) : EXT_W'(trial_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        id_sr <= voxel_id;
        cnt   <= '0;
        rem_a <= '0;
        rem_b <= '0;
        quo_k <= '0;
        k_ovf <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        id_sr <= {id_sr[ID_W-2:0], 1'b0};
        rem_a <= rem_a_next;
        rem_b <= rem_b_next;
        quo_k <= KW'({quo_k, bit_b});
        k_ovf <= k_ovf | quo_k[KW-1];
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(ID_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign coord_i = rem_a;
  assign coord_j = rem_b;
  assign coord_k = (k_ovf || 32'(quo_k) > MAX_DIM - 1) ? KW'(MAX_DIM - 1) : quo_k;

endmodule

/* sv/vbbc_mean.sv */
`timescale 1ns / 1ps

module vbbc_mean #(
  parameter int unsigned MAX_DIM = vbbc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vbbc_pkg::SUM_W-1:0]    dividend,
  input  logic [vbbc_pkg::TOTAL_W-1:0]  divisor,
  output logic                          done,
  output logic [$clog2(MAX_DIM)-1:0]    quotient
);
  import vbbc_pkg::*;

  localparam int unsigned KW    = $clog2(MAX_DIM);
  localparam int unsigned CNT_W = $clog2(SUM_W);

  // Restoring divider, one quotient bit per cycle. Only the low quotient
  // bits are kept; anything shifted past them marks the result as saturated.
  logic [SUM_W-1:0]   num_sr;
  logic [TOTAL_W-1:0] div_r;
  logic [TOTAL_W-1:0] rem;
  logic [KW-1:0]      quo;
  logic               ovf;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  logic [TOTAL_W:0]   trial;
  logic               qbit;
  logic [TOTAL_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, num_sr[SUM_W-1]};
    qbit     = trial >= {1'b0, div_r};
    rem_next = qbit ? TOTAL_W'(trial - {1'b0, div_r}) : TOTAL_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_sr <= dividend;
        div_r  <= divisor;
        rem    <= '0;
        quo    <= '0;
        ovf    <= 1'b0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        num_sr <= {num_sr[SUM_W-2:0], 1'b0};
        rem    <= rem_next;
        quo    <= KW'({quo, qbit});
        ovf    <= ovf | quo[KW-1];
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (ovf || 32'(quo) > MAX_DIM - 1) ? KW'(MAX_DIM - 1) : quo;

endmodule

/* sv/voxel_bounding_box_centroid_core.sv */
`timescale 1ns / 1ps

// Voxel bounding box and centroid core.
// The s_ channel carries one item per voxel of an object: a linear voxel id
// in tdata and tlast set on the final voxel of the object. For every item the
// m_ channel returns a coordinate result with the i, j and k coordinates of
// the voxel. After the item marked last, three summary results follow, one
// per axis, with the minimum, maximum and truncated mean coordinate; tlast
// on the m_ channel marks the final result caused by each input item.
// Extents are written through the cfg_ port; the user must write them only
// while the core is idle, as the core itself does not enforce this. An
// extent of zero acts as one and one above MAX_DIM acts as MAX_DIM. The
// coordinate split is a pair of chained bit-serial dividers that handle one
// id bit per cycle; no new item is accepted before the coordinate result of
// the previous one has entered the output register. The item marked last
// adds three serial divisions for the means before the next item is taken.
// A result sits in an output register; while the receiver stalls, the core
// still accepts and splits the next item and holds it until the register is
// free. Reset returns both extents to their default, clears the statistics
// and drops any item in flight.
module voxel_bounding_box_centroid_core #(
  parameter int unsigned MAX_DIM = vbbc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [vbbc_pkg::S_TDATA_W-1:0]    s_tdata,   // voxel_id[29:0], zero pad
  input  logic                              s_tlast,   // is_last
  // Result items.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [vbbc_pkg::M_TDATA_W-1:0]    m_tdata,   // coord_i, coord_j, coord_k,
                                                       // axis_min, axis_max, axis_mean,
                                                       // zero pad
  output logic [vbbc_pkg::M_TUSER_W-1:0]    m_tuser,   // record_kind, axis[1:0]
  output logic                              m_tlast,   // end_of_run
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [vbbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vbbc_pkg::EXT_W-1:0]        cfg_data
);
  import vbbc_pkg::*;

  localparam int unsigned KW = $clog2(MAX_DIM);
  localparam int unsigned CW = (KW > EXT_W) ? KW : EXT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_COORD,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_SUMMARY
  } state_t;

  state_t state;

  // Extents are stored already clamped to their effective value.
  logic [EXT_W-1:0] extent_x;
  logic [EXT_W-1:0] extent_y;

  logic             last_r;
  logic [1:0]       ax;

  logic [OUT_W-1:0]   min_coord [NUM_AXES];
  logic [OUT_W-1:0]   max_coord [NUM_AXES];
  logic [SUM_W-1:0]   coord_sum [NUM_AXES];
  logic [TOTAL_W-1:0] voxel_total;

  // Output register.
  logic             out_kind;
  logic [1:0]       out_axis;
  logic [OUT_W-1:0] out_i;
  logic [OUT_W-1:0] out_j;
  logic [OUT_W-1:0] out_k;
  logic [OUT_W-1:0] out_min;
  logic [OUT_W-1:0] out_max;
  logic [OUT_W-1:0] out_mean;
  logic             out_last;

  logic             split_start;
  logic             split_done;
  logic [EXT_W-1:0] split_i;
  logic [EXT_W-1:0] split_j;
  logic [KW-1:0]    split_k;

  logic             mean_start;
  logic             mean_done;
  logic [KW-1:0]    mean_q;

  logic             out_free;
  logic             emit_coord;
  logic             out_load;

  logic [CW-1:0]    c_full    [NUM_AXES];
  logic [OUT_W-1:0] c_low     [NUM_AXES];
  logic [SUM_W:0]   sum_wide  [NUM_AXES];
  logic [SUM_W-1:0] sum_next  [NUM_AXES];

  vbbc_split #(
    .MAX_DIM (MAX_DIM)
  ) u_split (
    .clk      (clk),
    .rst      (rst),
    .start    (split_start),
    .voxel_id (s_tdata[ID_W-1:0]),
    .ext_x    (extent_x),
    .ext_y    (extent_y),
    .done     (split_done),
    .coord_i  (split_i),
    .coord_j  (split_j),
    .coord_k  (split_k)
  );

  vbbc_mean #(
    .MAX_DIM (MAX_DIM)
  ) u_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (mean_start),
    .dividend (coord_sum[ax]),
    .divisor  (voxel_total),
    .done     (mean_done),
    .quotient (mean_q)
  );

  assign s_tready    = (state == ST_IDLE);
  assign split_start = s_tvalid && s_tready;
  assign mean_start  = (state == ST_MEAN_START);
  assign out_free    = !m_tvalid || m_tready;

  // The coordinate result leaves as soon as the split finishes and the output
  // register is free, or later from ST_COORD if the receiver was stalled.
  assign emit_coord = out_free &&
                      ((state == ST_SPLIT && split_done) || state == ST_COORD);

  // The output register takes a new result in this cycle.
  assign out_load = emit_coord || (state == ST_SUMMARY && out_free);

  // Coordinates at full width for the sums; the bounds keep the low bits.
  always_comb begin
    c_full[0] = CW'(split_i);
    c_full[1] = CW'(split_j);
    c_full[2] = CW'(split_k);
    for (int a = 0; a < NUM_AXES; a++) begin
      c_low[a]    = c_full[a][OUT_W-1:0];
      sum_wide[a] = {1'b0, coord_sum[a]} + (SUM_W+1)'(c_full[a]);
      sum_next[a] = sum_wide[a][SUM_W] ? '1 : sum_wide[a][SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      last_r      <= 1'b0;
      ax          <= AXIS_X;
      extent_x    <= eff_extent(EXTENT_RESET, MAX_DIM);
      extent_y    <= eff_extent(EXTENT_RESET, MAX_DIM);
      voxel_total <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        min_coord[a] <= '1;
        max_coord[a] <= '0;
        coord_sum[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EXTENT_X: extent_x <= eff_extent(cfg_data, MAX_DIM);
          REG_EXTENT_Y: extent_y <= eff_extent(cfg_data, MAX_DIM);
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            last_r <= s_tlast;
            state  <= ST_SPLIT;
          end
        end

        ST_SPLIT, ST_COORD: begin
          if (emit_coord) begin
            out_kind <= KIND_COORD;
            out_axis <= AXIS_X;
            out_i    <= c_low[0];
            out_j    <= c_low[1];
            out_k    <= c_low[2];
            out_min  <= '0;
            out_max  <= '0;
            out_mean <= '0;
            out_last <= !last_r;
            for (int a = 0; a < NUM_AXES; a++) begin
              if (c_low[a] < min_coord[a]) begin
                min_coord[a] <= c_low[a];
              end
              if (c_low[a] > max_coord[a]) begin
                max_coord[a] <= c_low[a];
              end
              coord_sum[a] <= sum_next[a];
            end
            if (voxel_total != '1) begin
              voxel_total <= voxel_total + 1'b1;
            end
            ax    <= AXIS_X;
            state <= last_r ? ST_MEAN_START : ST_IDLE;
          end else if (split_done) begin
            state <= ST_COORD;
          end
        end

        ST_MEAN_START: begin
          state <= ST_MEAN_WAIT;
        end

        ST_MEAN_WAIT: begin
          if (mean_done) begin
            state <= ST_SUMMARY;
          end
        end

        ST_SUMMARY: begin
          if (out_free) begin
            out_kind <= KIND_SUMMARY;
            out_axis <= ax;
            out_i    <= '0;
            out_j    <= '0;
            out_k    <= '0;
            out_min  <= min_coord[ax];
            out_max  <= max_coord[ax];
            out_mean <= OUT_W'(mean_q);
            out_last <= (ax == AXIS_Z);
            if (ax == AXIS_Z) begin
              // The object is finished: start the next one from scratch.
              voxel_total <= '0;
              for (int a = 0; a < NUM_AXES; a++) begin
                min_coord[a] <= '1;
                max_coord[a] <= '0;
                coord_sum[a] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              ax    <= ax + 1'b1;
              state <= ST_MEAN_START;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {(M_TDATA_W - 6 * OUT_W)'(0),
                    out_mean, out_max, out_min, out_k, out_j, out_i};
  assign m_tuser = {out_axis, out_kind};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // Only one item is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in flight");

  // The splitter only finishes while the controller waits for it.
  assert property (@(posedge clk) disable iff (rst)
    split_done |-> state == ST_SPLIT)
    else $error("coordinate split finished outside its wait state");

  // The mean divider only finishes while the controller waits for it.
  assert property (@(posedge clk) disable iff (rst)
    mean_done |-> state == ST_MEAN_WAIT)
    else $error("mean division finished outside its wait state");

  // A summary always covers at least one voxel, so its bounds are ordered.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == KIND_SUMMARY |-> out_min <= out_max)
    else $error("summary minimum above maximum");

  // Only the z-axis summary closes a run.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == KIND_SUMMARY |-> out_last == (out_axis == AXIS_Z))
    else $error("end of run on the wrong summary");
`endif

endmodule
